// ===== hdl/fbws_pkg.sv =====
package fbws_pkg;

  // Frame geometry
  localparam int FrameWidth  = 16;
  localparam int FrameHeight = 16;
  localparam int FrameDepth  = FrameWidth * FrameHeight;
  localparam int LineMax     = (FrameWidth > FrameHeight) ? FrameWidth : FrameHeight;

  // Address and counter widths
  localparam int AddrW  = $clog2(FrameDepth);
  localparam int CntW   = (LineMax > 2) ? $clog2(LineMax) : 1;
  localparam int ColorW = 24;

  // Commands
  localparam logic [1:0] CmdWrite  = 2'd0;
  localparam logic [1:0] CmdRead   = 2'd1;
  localparam logic [1:0] CmdScroll = 2'd2;

  // Scroll directions
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirRight = 2'd2;
  localparam logic [1:0] DirLeft  = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        column;
    logic [3:0]        row;
    logic [ColorW-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [ColorW-1:0] read_color;
    logic              done_res;
  } out_item_t;

  // Sequencer to line walker
  typedef struct packed {
    logic start;
    logic next;
  } walk_ctrl_t;

  // Line walker to sequencer
  typedef struct packed {
    logic last_pos;
    logic last_line;
  } walk_stat_t;

  // Linear pixel address: row * width + column
  function automatic logic [AddrW-1:0] pix_addr(input logic [CntW-1:0] x,
                                                input logic [CntW-1:0] y);
    int unsigned lin;
    lin = int'(y) * FrameWidth + int'(x);
    return lin[AddrW-1:0];
  endfunction

endpackage

// ===== hdl/framebuffer_wraparound_scroll.sv =====
// Channel  | Direction | Handshake                  | Payload
// input    | in        | in_valid_i / in_stall_o    | in_data_i   (fbws_pkg::in_item_t)
// output   | out       | out_valid_o / out_stall_i  | out_data_o  (fbws_pkg::out_item_t)
// config   | in        | cfg_we_i                   | cfg_wdata_i (scroll direction)
//
// After reset the frame memory is swept to black, one pixel a cycle, with the input
// stalled. A scroll reads then rewrites every pixel through the single frame memory
// port pair, plus one preload per line.
// A finished result waits in the output register; the next item is still taken,
// and it holds in its final state until the output register frees.
module framebuffer_wraparound_scroll (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbws_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fbws_pkg::out_item_t out_data_o
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_RDWAIT = 8'b0000_0100,
    ST_SC_PRE = 8'b0000_1000,
    ST_SC_CAP = 8'b0001_0000,
    ST_SC_RD  = 8'b0010_0000,
    ST_SC_WR  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                     dir_q;
  logic [fbws_pkg::AddrW-1:0]     clr_q, clr_d;
  logic [fbws_pkg::ColorW-1:0]    carry_q, carry_d;
  logic [fbws_pkg::ColorW-1:0]    res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  fbws_pkg::out_item_t            out_q, out_d;

  logic                           in_xfer;
  logic                           in_frame;
  logic [fbws_pkg::AddrW-1:0]     in_addr;

  logic                           ram_we;
  logic [fbws_pkg::AddrW-1:0]     ram_waddr;
  logic [fbws_pkg::ColorW-1:0]    ram_wdata;
  logic [fbws_pkg::AddrW-1:0]     ram_raddr;
  logic [fbws_pkg::ColorW-1:0]    ram_rdata;

  fbws_pkg::walk_ctrl_t           walk_ctrl;
  fbws_pkg::walk_stat_t           walk_stat;
  logic [fbws_pkg::AddrW-1:0]     cur_addr;
  logic [fbws_pkg::AddrW-1:0]     pre_addr;

  // Input transfer and pixel decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_frame   = (int'(in_data_i.column) < fbws_pkg::FrameWidth) &&
                      (int'(in_data_i.row) < fbws_pkg::FrameHeight);
  assign in_addr    = fbws_pkg::pix_addr(fbws_pkg::CntW'(in_data_i.column),
                                         fbws_pkg::CntW'(in_data_i.row));

  // Direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= fbws_pkg::DirUp;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  fbws_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dir_i      (dir_q),
    .ctrl_i     (walk_ctrl),
    .cur_addr_o (cur_addr),
    .pre_addr_o (pre_addr),
    .stat_o     (walk_stat)
  );

  fbws_ram #(
    .Width (fbws_pkg::ColorW),
    .Depth (fbws_pkg::FrameDepth)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    carry_d     = carry_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = carry_q;
    ram_raddr   = cur_addr;
    walk_ctrl   = '0;

    // Drop the output once it transfers
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (int'(clr_q) == fbws_pkg::FrameDepth - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = in_addr;
        ram_waddr = in_addr;
        ram_wdata = in_data_i.color;
        if (in_xfer) begin
          res_d   = '0;
          state_d = ST_FINISH;
          case (in_data_i.command)
            fbws_pkg::CmdWrite: begin
              ram_we = in_frame;
            end
            fbws_pkg::CmdRead: begin
              if (in_frame) begin
                state_d = ST_RDWAIT;
              end
            end
            fbws_pkg::CmdScroll: begin
              walk_ctrl.start = 1'b1;
              state_d         = ST_SC_PRE;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_d   = ram_rdata;
        state_d = ST_FINISH;
      end
      ST_SC_PRE: begin
        ram_raddr = pre_addr;
        state_d   = ST_SC_CAP;
      end
      ST_SC_CAP: begin
        carry_d = ram_rdata;
        state_d = ST_SC_RD;
      end
      ST_SC_RD: begin
        state_d = ST_SC_WR;
      end
      ST_SC_WR: begin
        // Write the carried pixel, carry the old one onward
        ram_we         = 1'b1;
        carry_d        = ram_rdata;
        walk_ctrl.next = 1'b1;
        if (walk_stat.last_pos) begin
          state_d = walk_stat.last_line ? ST_FINISH : ST_SC_PRE;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.read_color = res_q;
          out_d.done_res   = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/fbws_ram.sv =====
module fbws_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fbws_walk.sv =====
module fbws_walk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                dir_i,
  input  fbws_pkg::walk_ctrl_t      ctrl_i,
  output logic [fbws_pkg::AddrW-1:0] cur_addr_o,
  output logic [fbws_pkg::AddrW-1:0] pre_addr_o,
  output fbws_pkg::walk_stat_t      stat_o
);

  localparam logic [fbws_pkg::CntW-1:0] WLast = fbws_pkg::CntW'(fbws_pkg::FrameWidth - 1);
  localparam logic [fbws_pkg::CntW-1:0] HLast = fbws_pkg::CntW'(fbws_pkg::FrameHeight - 1);

  logic [fbws_pkg::CntW-1:0] step_q, step_d;
  logic [fbws_pkg::CntW-1:0] line_q, line_d;
  logic                      vert;
  logic                      fwd;
  logic [fbws_pkg::CntW-1:0] pos_last;
  logic [fbws_pkg::CntW-1:0] line_last;
  logic [fbws_pkg::CntW-1:0] pos;
  logic [fbws_pkg::CntW-1:0] pre_pos;

  // Decode direction: up/down walk columns, right/left walk rows
  always_comb begin
    vert      = (dir_i == fbws_pkg::DirUp) || (dir_i == fbws_pkg::DirDown);
    fwd       = (dir_i == fbws_pkg::DirUp) || (dir_i == fbws_pkg::DirRight);
    pos_last  = vert ? HLast : WLast;
    line_last = vert ? WLast : HLast;
    pos       = fwd ? step_q : pos_last - step_q;
    pre_pos   = fwd ? pos_last : '0;
  end

  // Map line and position to pixel addresses
  always_comb begin
    if (vert) begin
      cur_addr_o = fbws_pkg::pix_addr(line_q, pos);
      pre_addr_o = fbws_pkg::pix_addr(line_q, pre_pos);
    end else begin
      cur_addr_o = fbws_pkg::pix_addr(pos, line_q);
      pre_addr_o = fbws_pkg::pix_addr(pre_pos, line_q);
    end
  end

  assign stat_o.last_pos  = (step_q == pos_last);
  assign stat_o.last_line = (line_q == line_last);

  // Advance step within a line, then the line
  always_comb begin
    step_d = step_q;
    line_d = line_q;
    if (ctrl_i.start) begin
      step_d = '0;
      line_d = '0;
    end else if (ctrl_i.next) begin
      if (stat_o.last_pos) begin
        step_d = '0;
        line_d = line_q + 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      line_q <= '0;
    end else begin
      step_q <= step_d;
      line_q <= line_d;
    end
  end

endmodule
